### hw/rtl/swfr_pkg.sv
// Types and constants shared by the sync word frame receiver.
`default_nettype none

package swfr_pkg;

   // Receive phases of the deframer.
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN     = 3'd1,
      PH_CMD_LO  = 3'd2,
      PH_CMD_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } phase_type;

   // Result kinds carried on the result channel's tuser.
   typedef enum logic [1:0] {
      KIND_PAYLOAD    = 2'd0,
      KIND_ACCEPTED   = 2'd1,
      KIND_CHECK_ERR  = 2'd2,
      KIND_LENGTH_ERR = 2'd3
   } kind_type;

   localparam logic [31:0] SYNC_WORD        = 32'hFFFC_FCFF;
   localparam logic [7:0]  MIN_LENGTH       = 8'd2;
   localparam logic [7:0]  MAX_LENGTH_RESET = 8'hFF;

endpackage

`default_nettype wire

### hw/rtl/sync_word_frame_receiver.sv
// Sync word frame receiver: hunts for FF FC FC FF, deframes and checks each frame.
`default_nettype none

// Takes one received byte per item and hunts for the sync word FF FC FC FF in a
// sliding four-byte window. After the sync word come a length byte, a
// little-endian 16-bit command, length minus two payload bytes and a checksum
// byte that must equal the inverted 8-bit sum of length, command and payload.
// Each payload byte is passed on as it arrives; the checksum byte produces a
// frame accepted or checksum error result, and a length below two or above
// max_length produces a length error right after the length byte. Bytes outside
// a frame produce no result. Every item passes through an input register and
// combinational logic into the result register, so the block takes one item per
// clock as long as results are taken; a stalled result register holds the
// input register, and backpressure reaches the input side in the same cycle.
module sync_word_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration: max_length.
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata,
   // Input items.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Result items.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] data, [23:8] command,
                                         // [31:24] payload_length, [39:32] computed_check
   output logic [1:0]       rsp_tuser    // [1:0] kind
);

   logic [7:0]          max_length_ff;
   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   swfr_pkg::phase_type phase_ff, phase_in;
   logic [31:0]         window_ff, window_in;
   logic [7:0]          plen_ff, plen_in;
   logic [7:0]          left_ff, left_in;
   logic [7:0]          sum_ff, sum_in;
   logic [15:0]         cmd_ff, cmd_in;
   logic                out_valid_ff;
   logic [39:0]         out_data_ff;
   swfr_pkg::kind_type  out_kind_ff;

   logic                out_free;
   logic                step;
   logic                res_valid;
   swfr_pkg::kind_type  res_kind;
   logic [39:0]         res_data;
   logic [31:0]         shifted;
   logic [7:0]          check;
   logic                len_bad;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign shifted = {window_ff[23:0], in_byte_ff};
   assign check   = ~sum_ff;
   assign len_bad = (in_byte_ff < swfr_pkg::MIN_LENGTH) || (in_byte_ff > max_length_ff);

   // Next phase.
   always_comb begin
      case (phase_ff)
         swfr_pkg::PH_LEN: begin
            phase_in = len_bad ? swfr_pkg::PH_HUNT : swfr_pkg::PH_CMD_LO;
         end
         swfr_pkg::PH_CMD_LO: begin
            phase_in = swfr_pkg::PH_CMD_HI;
         end
         swfr_pkg::PH_CMD_HI: begin
            phase_in = (left_ff != 8'd0) ? swfr_pkg::PH_PAYLOAD : swfr_pkg::PH_CHECK;
         end
         swfr_pkg::PH_PAYLOAD: begin
            phase_in = (left_ff == 8'd1) ? swfr_pkg::PH_CHECK : swfr_pkg::PH_PAYLOAD;
         end
         swfr_pkg::PH_CHECK: begin
            phase_in = swfr_pkg::PH_HUNT;
         end
         default: begin
            phase_in = (shifted == swfr_pkg::SYNC_WORD) ? swfr_pkg::PH_LEN
                                                        : swfr_pkg::PH_HUNT;
         end
      endcase
   end

   // Frame state updates and the result of the current item.
   always_comb begin
      window_in = window_ff;
      plen_in   = plen_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      cmd_in    = cmd_ff;
      res_valid = 1'b0;
      res_kind  = swfr_pkg::KIND_PAYLOAD;
      res_data  = '0;
      case (phase_ff)
         swfr_pkg::PH_LEN: begin
            if (len_bad) begin
               window_in = '0;
               res_valid = 1'b1;
               res_kind  = swfr_pkg::KIND_LENGTH_ERR;
            end else begin
               plen_in = in_byte_ff - swfr_pkg::MIN_LENGTH;
               left_in = in_byte_ff - swfr_pkg::MIN_LENGTH;
               sum_in  = in_byte_ff;
            end
         end
         swfr_pkg::PH_CMD_LO: begin
            cmd_in = {8'd0, in_byte_ff};
            sum_in = sum_ff + in_byte_ff;
         end
         swfr_pkg::PH_CMD_HI: begin
            cmd_in = {in_byte_ff, cmd_ff[7:0]};
            sum_in = sum_ff + in_byte_ff;
         end
         swfr_pkg::PH_PAYLOAD: begin
            sum_in    = sum_ff + in_byte_ff;
            left_in   = left_ff - 8'd1;
            res_valid = 1'b1;
            res_kind  = swfr_pkg::KIND_PAYLOAD;
            res_data  = {8'd0, plen_ff, cmd_ff, in_byte_ff};
         end
         swfr_pkg::PH_CHECK: begin
            window_in = '0;
            res_valid = 1'b1;
            res_kind  = (check == in_byte_ff) ? swfr_pkg::KIND_ACCEPTED
                                              : swfr_pkg::KIND_CHECK_ERR;
            res_data  = {check, plen_ff, cmd_ff, in_byte_ff};
         end
         default: begin
            // Hunting: a match empties the window and starts a new frame.
            if (shifted == swfr_pkg::SYNC_WORD) begin
               window_in = '0;
               sum_in    = '0;
            end else begin
               window_in = shifted;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= swfr_pkg::MAX_LENGTH_RESET;
         in_valid_ff   <= 1'b0;
         phase_ff      <= swfr_pkg::PH_HUNT;
         window_ff     <= '0;
         plen_ff       <= '0;
         left_ff       <= '0;
         sum_ff        <= '0;
         cmd_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            max_length_ff <= csr_wdata;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (step) begin
            phase_ff  <= phase_in;
            window_ff <= window_in;
            plen_ff   <= plen_in;
            left_ff   <= left_in;
            sum_ff    <= sum_in;
            cmd_ff    <= cmd_in;
         end
         if (out_free) begin
            out_valid_ff <= step && res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (step && res_valid) begin
         out_data_ff <= res_data;
         out_kind_ff <= res_kind;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;

`ifndef SYNTH
   // A length error always sends the deframer back to hunting.
   assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == swfr_pkg::PH_LEN && len_bad |=> phase_ff == swfr_pkg::PH_HUNT)
      else $error("length error did not return to hunting");

   // Payload results come only from the payload phase.
   assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res_kind == swfr_pkg::KIND_PAYLOAD
         |-> phase_ff == swfr_pkg::PH_PAYLOAD)
      else $error("payload result outside the payload phase");

   // A full input register facing a stalled result register takes no new item.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while the pipeline is stalled");
`endif

endmodule

`default_nettype wire
